// ===== hw/rtl/rfbl_pkg.sv =====
package rfbl_pkg;

  localparam int NUM_FIFOS_DEF   = 4;
  localparam int FIFO_DEPTH_DEF  = 64;
  localparam int HANDLE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_ADV = 2'd2,
    KIND_SET = 2'd3
  } kind_t;

endpackage

// ===== hw/rtl/rotating_fifo_bank_level_unit.sv =====
// One calendar-queue level: a bank of NUM_FIFOS handle FIFOs with a serving pointer.
// Input: an item transfers at a rising edge with start high and busy low. in_kind
// selects enqueue into FIFO in_fifo_index, dequeue from the serving FIFO, advance
// the serving pointer (wrapping) or set it to in_fifo_index.
// Output: every item gives one result, shown for exactly one cycle with out_strobe
// high; it transfers at the edge that ends that cycle. The receiver cannot stall.
// Timing: after the accepting edge the item passes through ST_UPD and ST_OUT, with
// busy high in both; out_strobe rises as the state returns to ST_IDLE, so a new item can
// be accepted in the cycle that shows the previous result.
// This sequence is set by the metadata RAM's one read port: one read of the target
// queue's head/tail/length, then the write-back alongside a read of the serving
// queue, then the result register. Handles sit in a separate NUM_FIFOS*FIFO_DEPTH
// entry RAM.
// Reset (synchronous, rst_n low) empties all queues, sets the pointer and the
// level count to zero and drops any item in flight. Metadata entries carry valid
// bits, so no clearing pass is needed; the handle RAM is never cleared.
module rotating_fifo_bank_level_unit #(
  parameter int NUM_FIFOS   = rfbl_pkg::NUM_FIFOS_DEF,
  parameter int FIFO_DEPTH  = rfbl_pkg::FIFO_DEPTH_DEF,
  parameter int HANDLE_BITS = rfbl_pkg::HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [1:0]  in_fifo_index,
  input  logic [15:0] in_packet_handle,
  output logic        out_strobe,
  output logic        out_packet_valid,
  output logic [15:0] out_packet_out,
  output logic        out_overflow,
  output logic [1:0]  out_serving_index,
  output logic [6:0]  out_serving_length,
  output logic        out_serving_empty,
  output logic [8:0]  out_level_count
);

  localparam int PW  = $clog2(NUM_FIFOS);
  localparam int AW  = $clog2(FIFO_DEPTH);
  localparam int LW  = $clog2(FIFO_DEPTH + 1);
  localparam int SAW = $clog2(NUM_FIFOS * FIFO_DEPTH);
  localparam int TW  = $clog2(NUM_FIFOS * FIFO_DEPTH + 1);
  localparam int SW  = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

  localparam logic [AW:0]    DEPTH_W = (AW + 1)'(FIFO_DEPTH);
  localparam logic [LW-1:0]  DEPTH_L = LW'(FIFO_DEPTH);
  localparam logic [SAW-1:0] DEPTH_S = SAW'(FIFO_DEPTH);
  localparam logic [PW-1:0]  LAST_Q  = PW'(NUM_FIFOS - 1);

  typedef struct packed {
    logic [AW-1:0] head;
    logic [AW-1:0] tail;
    logic [LW-1:0] len;
  } meta_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_OUT
  } state_t;

  function automatic logic [AW-1:0] wrap_pos(input logic [AW-1:0] p);
    logic [AW:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= DEPTH_W) ? '0 : n[AW-1:0];
  endfunction

  state_t              state_r;
  rfbl_pkg::kind_t     kind_r;
  logic                idx_ok_r;
  logic [PW-1:0]       q_r;
  logic [SW-1:0]       hnd_r;
  logic [PW-1:0]       ptr_r;
  logic [TW-1:0]       total_r;
  logic [NUM_FIFOS-1:0] meta_vld_r;
  logic                pv_r;
  logic                ovf_r;
  logic                fwd_r;
  logic [LW-1:0]       fwd_len_r;

  logic                out_strobe_r;
  logic                out_pv_r;
  logic [15:0]         out_pkt_r;
  logic                out_ovf_r;
  logic [1:0]          out_idx_r;
  logic [6:0]          out_len_r;
  logic                out_empty_r;
  logic [8:0]          out_cnt_r;

  // metadata RAM: one read port, one write port
  meta_t               meta_mem [NUM_FIFOS];
  meta_t               meta_rd_r;
  logic                meta_rdv_r;
  logic [PW-1:0]       meta_raddr;
  logic                meta_we;
  meta_t               meta_new;

  // handle RAM: one address, read or write
  logic [SW-1:0]       store_mem [NUM_FIFOS * FIFO_DEPTH];
  logic [SW-1:0]       store_rd_r;
  logic [SAW-1:0]      store_addr;
  logic                store_we;

  rfbl_pkg::kind_t     in_kind_c;
  logic                idx_ok;
  logic [PW-1:0]       ptr_adv;
  logic [PW-1:0]       ptr_nxt;
  logic [PW-1:0]       q_sel;
  logic                accept;
  meta_t               meta_cur;
  logic                enq_ok;
  logic                deq_ok;
  logic [AW-1:0]       pos;
  logic [LW-1:0]       srv_len;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign in_kind_c = rfbl_pkg::kind_t'(in_kind);
  assign idx_ok    = ({30'b0, in_fifo_index} < 32'(NUM_FIFOS));
  assign ptr_adv   = (ptr_r == LAST_Q) ? '0 : ptr_r + 1'b1;

  always_comb begin
    ptr_nxt = ptr_r;
    q_sel   = ptr_r;
    case (in_kind_c)
      rfbl_pkg::KIND_ENQ: begin
        if (idx_ok) q_sel = PW'(in_fifo_index);
      end
      rfbl_pkg::KIND_DEQ: begin
        q_sel = ptr_r;
      end
      rfbl_pkg::KIND_ADV: begin
        ptr_nxt = ptr_adv;
        q_sel   = ptr_adv;
      end
      rfbl_pkg::KIND_SET: begin
        if (idx_ok) begin
          ptr_nxt = PW'(in_fifo_index);
          q_sel   = PW'(in_fifo_index);
        end
      end
      default: begin
        q_sel = ptr_r;
      end
    endcase
  end

  // read-modify-write of the target queue, valid in ST_UPD
  always_comb begin
    meta_cur = meta_rdv_r ? meta_rd_r : '0;
    enq_ok   = (kind_r == rfbl_pkg::KIND_ENQ) && idx_ok_r && (meta_cur.len < DEPTH_L);
    deq_ok   = (kind_r == rfbl_pkg::KIND_DEQ) && (meta_cur.len != '0);
    meta_new = meta_cur;
    if (enq_ok) begin
      meta_new.tail = wrap_pos(meta_cur.tail);
      meta_new.len  = meta_cur.len + 1'b1;
    end else if (deq_ok) begin
      meta_new.head = wrap_pos(meta_cur.head);
      meta_new.len  = meta_cur.len - 1'b1;
    end
  end

  assign meta_we    = (state_r == ST_UPD) && (enq_ok || deq_ok);
  assign meta_raddr = (state_r == ST_IDLE) ? q_sel : ptr_r;
  assign pos        = enq_ok ? meta_cur.tail : meta_cur.head;
  assign store_addr = SAW'(q_r) * DEPTH_S + SAW'(pos);
  assign store_we   = (state_r == ST_UPD) && enq_ok;
  assign srv_len    = fwd_r ? fwd_len_r : (meta_rdv_r ? meta_rd_r.len : '0);

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[q_r] <= meta_new;
    meta_rd_r  <= meta_mem[meta_raddr];
    meta_rdv_r <= meta_vld_r[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_addr] <= hnd_r;
    store_rd_r <= store_mem[store_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ptr_r        <= '0;
      total_r      <= '0;
      meta_vld_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            kind_r   <= in_kind_c;
            idx_ok_r <= idx_ok;
            q_r      <= q_sel;
            hnd_r    <= in_packet_handle[SW-1:0];
            ptr_r    <= ptr_nxt;
            state_r  <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (meta_we) meta_vld_r[q_r] <= 1'b1;
          if (enq_ok) begin
            total_r <= total_r + 1'b1;
          end else if (deq_ok && (total_r != '0)) begin
            total_r <= total_r - 1'b1;
          end
          pv_r      <= deq_ok;
          ovf_r     <= (kind_r == rfbl_pkg::KIND_ENQ) && !enq_ok;
          // serving queue read races the write-back of the same entry
          fwd_r     <= meta_we && (ptr_r == q_r);
          fwd_len_r <= meta_new.len;
          state_r   <= ST_OUT;
        end
        ST_OUT: begin
          out_strobe_r <= 1'b1;
          out_pv_r     <= pv_r;
          out_pkt_r    <= pv_r ? 16'(store_rd_r) : 16'd0;
          out_ovf_r    <= ovf_r;
          out_idx_r    <= 2'(ptr_r);
          out_len_r    <= 7'(srv_len);
          out_empty_r  <= (srv_len == '0);
          out_cnt_r    <= 9'(total_r);
          state_r      <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_packet_valid   = out_pv_r;
  assign out_packet_out     = out_pkt_r;
  assign out_overflow       = out_ovf_r;
  assign out_serving_index  = out_idx_r;
  assign out_serving_length = out_len_r;
  assign out_serving_empty  = out_empty_r;
  assign out_level_count    = out_cnt_r;

endmodule

// ===== hw/rtl/rfbl_checker.sv =====
module rfbl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_packet_valid,
  input logic [15:0] out_packet_out,
  input logic        out_overflow,
  input logic [6:0]  out_serving_length,
  input logic        out_serving_empty
);

  // each transfer in yields its result strobe after the item has passed ST_UPD and ST_OUT
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("result strobe missing after accepted item");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe repeated");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  a_no_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_packet_valid) |-> (out_packet_out == 16'd0))
    else $error("handle nonzero without packet_valid");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!(out_packet_valid && out_overflow) &&
                    (out_serving_empty == (out_serving_length == 7'd0))))
    else $error("inconsistent result flags");

endmodule

bind rotating_fifo_bank_level_unit rfbl_checker u_rfbl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_packet_valid   (out_packet_valid),
  .out_packet_out     (out_packet_out),
  .out_overflow       (out_overflow),
  .out_serving_length (out_serving_length),
  .out_serving_empty  (out_serving_empty)
);
